// ===== rtl/psc_pkg.sv =====
package psc_pkg;

	localparam logic [15:0] MIN_FRAME_BYTES = 16'd54;
	localparam logic [7:0]  PROTO_TCP       = 8'd6;

	localparam logic [1:0] REG_WATCHED_PORT   = 2'd0;
	localparam logic [1:0] REG_INTERVAL_LIMIT = 2'd1;
	localparam logic [1:0] REG_RETX_LIMIT     = 2'd2;
	localparam logic [1:0] REG_NOTIFY_LIMIT   = 2'd3;

	localparam logic [15:0] WATCHED_PORT_RST   = 16'd1935;
	localparam logic [31:0] INTERVAL_LIMIT_RST = 32'd1000000;
	localparam logic [31:0] RETX_LIMIT_RST     = 32'd3;
	localparam logic [31:0] NOTIFY_LIMIT_RST   = 32'd10;

	typedef struct packed {
		logic [15:0] packet_length;
		logic [7:0]  ip_protocol;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [31:0] source_address;
		logic        flag_syn;
		logic        flag_rst;
		logic        flag_fin;
		logic [63:0] arrival_ns;
	} item_t;

	typedef struct packed {
		logic        tracked;
		logic        table_full;
		logic        congestion;
		logic [31:0] notify_value;
		logic [31:0] flagged_total;
		logic [63:0] congestion_since_ns;
	} result_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] key;
		logic [63:0] last_seen_ns;
		logic [31:0] plain_total;
		logic [31:0] flagged_count;
		logic [63:0] congestion_start_ns;
	} entry_t;

endpackage

// ===== rtl/psc_table.sv =====
module psc_table #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output psc_pkg::entry_t  rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  psc_pkg::entry_t  wr_data
);

	psc_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/per_source_congestion_detector.sv =====
// channel   direction  handshake              payload
// item      in         start & !busy          item   (psc_pkg::item_t)
// result    out        done, one cycle        result (psc_pkg::result_t)
// config    in         cfg_we                 cfg_index, cfg_data
//
// done rises from the qualify state when the word does not qualify; when it does,
// the word passes check (once per probe), calc and decide, done rising from decide:
// the flow table is a hashed memory with linear probing, one entry read per cycle.
// a full table with a new source takes TABLE_ENTRIES probes, done then rising from
// the check state with table_full set. after reset busy stays high while a clearing
// pass zeroes the table. results cannot be stalled; done pulses for one cycle per word.
module per_source_congestion_detector #(
	parameter int TABLE_ENTRIES = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  psc_pkg::item_t    item,
	output logic              done,
	output psc_pkg::result_t  result,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data
);

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [AW:0]   DEPTH_W = (AW + 1)'(TABLE_ENTRIES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);
	localparam logic [CW-1:0] PROBE_MAX = CW'(TABLE_ENTRIES);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_QUAL  = 3'd2;
	localparam logic [2:0] ST_CHK   = 3'd3;
	localparam logic [2:0] ST_CALC  = 3'd4;
	localparam logic [2:0] ST_DEC   = 3'd5;

	logic [2:0]       state_q;
	logic [AW-1:0]    addr_q;
	logic [CW-1:0]    probes_q;
	psc_pkg::item_t   item_q;
	psc_pkg::entry_t  entry_q;
	logic             gap_lt_q;
	logic [31:0]      notify_q;
	logic [15:0]      watched_port_q;
	logic [31:0]      interval_limit_q;
	logic [31:0]      retx_limit_q;
	logic [31:0]      notify_limit_q;

	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	psc_pkg::entry_t  rd_data;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	psc_pkg::entry_t  wr_data;

	logic [31:0]      key_shift;
	logic [AW-1:0]    fold;
	logic [AW-1:0]    hash;
	logic [AW-1:0]    next_addr;
	logic             qualifies;
	logic             flagged;
	logic             cong;
	logic [31:0]      notify_inc;
	logic [31:0]      notify_next;
	logic [63:0]      cstart_next;
	logic [63:0]      gap;

	psc_table #(.DEPTH(TABLE_ENTRIES), .AW(AW)) u_table (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// xor fold of the source address, brought below the table depth
	assign key_shift = item_q.source_address >> AW;
	assign fold = item_q.source_address[AW-1:0] ^ key_shift[AW-1:0];
	assign hash = ({1'b0, fold} >= DEPTH_W) ? AW'({1'b0, fold} - DEPTH_W) : fold;
	assign next_addr = (addr_q == LAST_ADDR) ? '0 : addr_q + 1'b1;

	assign qualifies = (item_q.packet_length >= psc_pkg::MIN_FRAME_BYTES) &&
		(item_q.ip_protocol == psc_pkg::PROTO_TCP) &&
		((item_q.source_port == watched_port_q) || (item_q.dest_port == watched_port_q));
	assign flagged = item_q.flag_syn | item_q.flag_rst | item_q.flag_fin;
	assign gap = item_q.arrival_ns - entry_q.last_seen_ns;

	assign cong = gap_lt_q || (entry_q.flagged_count >= retx_limit_q);
	assign notify_inc = notify_q + 32'd1;
	assign notify_next = !cong ? '0 : ((notify_inc > notify_limit_q) ? 32'd1 : notify_inc);
	assign cstart_next = !cong ? '0 :
		((entry_q.congestion_start_ns == '0) ? item_q.arrival_ns : entry_q.congestion_start_ns);

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		rd_en = 1'b0;
		rd_addr = hash;
		wr_en = 1'b0;
		wr_addr = addr_q;
		wr_data = entry_q;
		case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
				wr_data = '0;
			end
			ST_QUAL: begin
				rd_en = qualifies;
			end
			ST_CHK: begin
				rd_addr = next_addr;
				rd_en = rd_data.valid && (rd_data.key != item_q.source_address) &&
					(probes_q != PROBE_MAX);
			end
			ST_DEC: begin
				wr_en = 1'b1;
				wr_data.congestion_start_ns = cstart_next;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			addr_q <= '0;
			probes_q <= '0;
			done <= 1'b0;
			notify_q <= '0;
			watched_port_q <= psc_pkg::WATCHED_PORT_RST;
			interval_limit_q <= psc_pkg::INTERVAL_LIMIT_RST;
			retx_limit_q <= psc_pkg::RETX_LIMIT_RST;
			notify_limit_q <= psc_pkg::NOTIFY_LIMIT_RST;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					psc_pkg::REG_WATCHED_PORT:   watched_port_q <= cfg_data[15:0];
					psc_pkg::REG_INTERVAL_LIMIT: interval_limit_q <= cfg_data;
					psc_pkg::REG_RETX_LIMIT:     retx_limit_q <= cfg_data;
					psc_pkg::REG_NOTIFY_LIMIT:   notify_limit_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_CLEAR: begin
					done <= 1'b0;
					addr_q <= next_addr;
					if (addr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					done <= 1'b0;
					if (start) begin
						state_q <= ST_QUAL;
					end
				end
				ST_QUAL: begin
					addr_q <= hash;
					probes_q <= CW'(1);
					done <= !qualifies;
					if (qualifies) begin
						state_q <= ST_CHK;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_CHK: begin
					done <= rd_data.valid && (rd_data.key != item_q.source_address) &&
						(probes_q == PROBE_MAX);
					if (rd_data.valid && (rd_data.key == item_q.source_address)) begin
						state_q <= ST_CALC;
					end else if (!rd_data.valid) begin
						state_q <= ST_CALC;
					end else if (probes_q == PROBE_MAX) begin
						state_q <= ST_IDLE;
					end else begin
						addr_q <= next_addr;
						probes_q <= probes_q + 1'b1;
					end
				end
				ST_CALC: begin
					done <= 1'b0;
					state_q <= ST_DEC;
				end
				ST_DEC: begin
					notify_q <= notify_next;
					done <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					done <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					item_q <= item;
				end
			end
			ST_QUAL: begin
				result <= '{tracked: 1'b0, table_full: 1'b0, congestion: 1'b0,
					notify_value: notify_q, flagged_total: 32'd0,
					congestion_since_ns: 64'd0};
			end
			ST_CHK: begin
				if (rd_data.valid && (rd_data.key == item_q.source_address)) begin
					entry_q <= rd_data;
				end else if (!rd_data.valid) begin
					// new source starts zeroed
					entry_q <= '{valid: 1'b1, key: item_q.source_address,
						last_seen_ns: 64'd0, plain_total: 32'd0, flagged_count: 32'd0,
						congestion_start_ns: 64'd0};
				end else if (probes_q == PROBE_MAX) begin
					result.table_full <= 1'b1;
				end
			end
			ST_CALC: begin
				gap_lt_q <= gap < {32'd0, interval_limit_q};
				entry_q <= '{valid: entry_q.valid, key: entry_q.key,
					last_seen_ns: item_q.arrival_ns,
					plain_total: flagged ? entry_q.plain_total : entry_q.plain_total + 32'd1,
					flagged_count: flagged ? entry_q.flagged_count + 32'd1 :
						entry_q.flagged_count,
					congestion_start_ns: entry_q.congestion_start_ns};
			end
			ST_DEC: begin
				result <= '{tracked: 1'b1, table_full: 1'b0, congestion: cong,
					notify_value: notify_next, flagged_total: entry_q.flagged_count,
					congestion_since_ns: cstart_next};
			end
			default: ;
		endcase
	end

endmodule
